// File: rtl/mi3_pkg.sv
package mi3_pkg;

    localparam int ENTRY_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int LANES         = 9;

    typedef struct packed {
        logic valid;
        logic singular;
    } t_div_ctl;

endpackage

// File: rtl/mi3_div.sv
module mi3_div #(
    parameter int ENTRY_WIDTH = mi3_pkg::ENTRY_WIDTH,
    parameter int NUM_WIDTH   = 3 * mi3_pkg::ENTRY_WIDTH + 1,
    parameter int DEN_WIDTH   = 3 * mi3_pkg::ENTRY_WIDTH + 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mi3_pkg::t_div_ctl             i_ctl,
    input  logic [NUM_WIDTH-1:0]          i_num   [mi3_pkg::LANES],
    input  logic                          i_neg   [mi3_pkg::LANES],
    input  logic [DEN_WIDTH-1:0]          i_den,
    output mi3_pkg::t_div_ctl             o_ctl,
    output logic signed [ENTRY_WIDTH-1:0] o_inv   [mi3_pkg::LANES],
    output logic                          o_clipped
);

    localparam int E  = ENTRY_WIDTH;
    localparam int L  = mi3_pkg::LANES;
    localparam int XW = ((NUM_WIDTH > DEN_WIDTH + E) ? NUM_WIDTH : DEN_WIDTH + E) + 1;

    logic [XW-1:0]        r_rem [0:E][L];
    logic [E-1:0]         r_q   [0:E][L];
    logic                 r_neg [0:E][L];
    logic                 r_ovf [0:E][L];
    logic [DEN_WIDTH-1:0] r_den [0:E];
    mi3_pkg::t_div_ctl    r_ctl [0:E];

    logic [L-1:0]         n_clip;
    logic signed [E-1:0]  n_inv [L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
        r_den[0] <= i_den;
        for (int k = 0; k < L; k++) begin
            r_rem[0][k] <= XW'(i_num[k]);
            r_q[0][k]   <= '0;
            r_neg[0][k] <= i_neg[k];
            r_ovf[0][k] <= XW'(i_num[k]) >= (XW'(i_den) << E);
        end
    end

    for (genvar s = 0; s < E; s++) begin : g_step
        localparam int B = E - 1 - s;
        logic [XW-1:0] n_dsh;
        assign n_dsh = XW'(r_den[s]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s+1] <= '0;
            end else begin
                r_ctl[s+1] <= r_ctl[s];
            end
            r_den[s+1] <= r_den[s];
            for (int k = 0; k < L; k++) begin
                r_neg[s+1][k] <= r_neg[s][k];
                r_ovf[s+1][k] <= r_ovf[s][k];
                if (r_rem[s][k] >= n_dsh) begin
                    r_rem[s+1][k] <= r_rem[s][k] - n_dsh;
                    r_q[s+1][k]   <= r_q[s][k] | (E'(1) << B);
                end else begin
                    r_rem[s+1][k] <= r_rem[s][k];
                    r_q[s+1][k]   <= r_q[s][k];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < L; k++) begin
            if (!r_neg[E][k]) begin
                n_clip[k] = r_ovf[E][k] | r_q[E][k][E-1];
                n_inv[k]  = n_clip[k] ? {1'b0, {(E-1){1'b1}}} : r_q[E][k];
            end else begin
                n_clip[k] = r_ovf[E][k] | (r_q[E][k][E-1] & (|r_q[E][k][E-2:0]));
                n_inv[k]  = n_clip[k] ? {1'b1, {(E-1){1'b0}}} : E'(-r_q[E][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= r_ctl[E];
        end
        o_clipped <= !r_ctl[E].singular && (|n_clip);
        for (int k = 0; k < L; k++) begin
            o_inv[k] <= r_ctl[E].singular ? '0 : n_inv[k];
        end
    end

endmodule

// File: rtl/matrix_inverse_3x3.sv
// Throughput: one matrix per cycle; busy stays low, the divider bank runs one
// restoring step per stage for all nine entries in parallel.
// Reset: synchronous, active low; clears the valid bits of every stage.
// Results are shown for one cycle; the receiver cannot stall them.
module matrix_inverse_3x3 #(
    parameter int ENTRY_WIDTH   = mi3_pkg::ENTRY_WIDTH,
    parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [ENTRY_WIDTH-1:0] i_m00,
    input  logic signed [ENTRY_WIDTH-1:0] i_m01,
    input  logic signed [ENTRY_WIDTH-1:0] i_m02,
    input  logic signed [ENTRY_WIDTH-1:0] i_m10,
    input  logic signed [ENTRY_WIDTH-1:0] i_m11,
    input  logic signed [ENTRY_WIDTH-1:0] i_m12,
    input  logic signed [ENTRY_WIDTH-1:0] i_m20,
    input  logic signed [ENTRY_WIDTH-1:0] i_m21,
    input  logic signed [ENTRY_WIDTH-1:0] i_m22,
    output logic                          o_strobe,
    output logic signed [ENTRY_WIDTH-1:0] o_inv00,
    output logic signed [ENTRY_WIDTH-1:0] o_inv01,
    output logic signed [ENTRY_WIDTH-1:0] o_inv02,
    output logic signed [ENTRY_WIDTH-1:0] o_inv10,
    output logic signed [ENTRY_WIDTH-1:0] o_inv11,
    output logic signed [ENTRY_WIDTH-1:0] o_inv12,
    output logic signed [ENTRY_WIDTH-1:0] o_inv20,
    output logic signed [ENTRY_WIDTH-1:0] o_inv21,
    output logic signed [ENTRY_WIDTH-1:0] o_inv22,
    output logic                          o_singular,
    output logic                          o_clipped
);

    localparam int E  = ENTRY_WIDTH;
    localparam int L  = mi3_pkg::LANES;
    localparam int PW = 2 * E;
    localparam int CW = 2 * E + 1;
    localparam int TW = 2 * E + 1;
    localparam int DW = 3 * E + 3;
    localparam int NW = CW + 2 * FRACTION_BITS;

    localparam int OPA [L] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int OPB [L] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int OPC [L] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int OPD [L] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
    localparam int DCOF [3] = '{0, 3, 6};

    logic signed [E-1:0]  a [L];
    logic                 w_accept;

    logic [4:0]           r_vld;
    logic signed [PW-1:0] r_pa  [L];
    logic signed [PW-1:0] r_pb  [L];
    logic signed [E-1:0]  r_row1 [3];
    logic signed [E-1:0]  r_row2 [3];
    logic signed [CW-1:0] r_cof2 [L];
    logic signed [CW-1:0] r_cof3 [L];
    logic signed [CW-1:0] r_cof4 [L];
    logic signed [TW-1:0] r_plo [3];
    logic signed [TW-1:0] r_phi [3];
    logic signed [DW-1:0] r_det;
    logic signed [DW-1:0] n_det;

    logic [NW-1:0]        r_num [L];
    logic                 r_neg [L];
    logic [DW-1:0]        r_dmag;
    logic                 r_dzero;

    mi3_pkg::t_div_ctl    w_ctl;
    mi3_pkg::t_div_ctl    w_octl;
    logic signed [E-1:0]  w_inv [L];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign a[0] = i_m00;
    assign a[1] = i_m01;
    assign a[2] = i_m02;
    assign a[3] = i_m10;
    assign a[4] = i_m11;
    assign a[5] = i_m12;
    assign a[6] = i_m20;
    assign a[7] = i_m21;
    assign a[8] = i_m22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < L; k++) begin
            r_pa[k] <= PW'(a[OPA[k]]) * PW'(a[OPB[k]]);
            r_pb[k] <= PW'(a[OPC[k]]) * PW'(a[OPD[k]]);
        end
        for (int j = 0; j < 3; j++) begin
            r_row1[j] <= a[j];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < L; k++) begin
            r_cof2[k] <= CW'(r_pa[k]) - CW'(r_pb[k]);
        end
        r_row2 <= r_row1;
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_plo[j] <= TW'($signed({1'b0, r_cof2[DCOF[j]][E-1:0]})) * TW'(r_row2[j]);
            r_phi[j] <= TW'($signed(r_cof2[DCOF[j]][CW-1:E])) * TW'(r_row2[j]);
        end
        r_cof3 <= r_cof2;
    end

    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (DW'(r_phi[j]) <<< E) + DW'(r_plo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_det  <= n_det;
        r_cof4 <= r_cof3;
    end

    always_ff @(posedge i_clk) begin
        r_dzero <= (r_det == '0);
        r_dmag  <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        for (int k = 0; k < L; k++) begin
            r_neg[k] <= r_cof4[k][CW-1] ^ r_det[DW-1];
            r_num[k] <= NW'(r_cof4[k][CW-1] ? CW'(-r_cof4[k]) : CW'(r_cof4[k]))
                        << (2 * FRACTION_BITS);
        end
    end

    assign w_ctl.valid    = r_vld[4];
    assign w_ctl.singular = r_dzero;

    mi3_div #(
        .ENTRY_WIDTH (E),
        .NUM_WIDTH   (NW),
        .DEN_WIDTH   (DW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_num     (r_num),
        .i_neg     (r_neg),
        .i_den     (r_dmag),
        .o_ctl     (w_octl),
        .o_inv     (w_inv),
        .o_clipped (o_clipped)
    );

    assign o_strobe   = w_octl.valid;
    assign o_singular = w_octl.singular;
    assign o_inv00    = w_inv[0];
    assign o_inv01    = w_inv[1];
    assign o_inv02    = w_inv[2];
    assign o_inv10    = w_inv[3];
    assign o_inv11    = w_inv[4];
    assign o_inv12    = w_inv[5];
    assign o_inv20    = w_inv[6];
    assign o_inv21    = w_inv[7];
    assign o_inv22    = w_inv[8];

endmodule
